>>> sv/rins_pkg.sv
// Package for the record insertion sorter: sizes, record and control types.
// Used by rins_ctrl and record_insertion_sorter; depends on nothing.
package rins_pkg;

   localparam int MAX_RECORDS = 32;
   localparam int KEY_BITS    = 16;
   localparam int PAY_BITS    = 16;
   localparam int IDX_BITS    = $clog2(MAX_RECORDS);
   localparam int CNT_BITS    = $clog2(MAX_RECORDS + 1);
   localparam int ENTRY_BITS  = KEY_BITS + PAY_BITS;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [PAY_BITS-1:0] pay;
   } entry_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_KEY,
      ST_SHIFT,
      ST_PLACE,
      ST_READ,
      ST_LATCH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_addr;
      entry_type           wr_data;
      logic [IDX_BITS-1:0] rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic latch;
      logic valid;
      logic final_rec;
      logic overflow;
   } emit_type;

endpackage

>>> sv/rins_if.sv
// Item channels of the record insertion sorter: request and response.
// Depends on nothing.
interface rins_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] key_volume;
   logic [15:0] payload_capacity;
   logic        batch_end;

   modport source (output valid, output key_volume, output payload_capacity,
                   output batch_end, input ready);
   modport sink (input valid, input key_volume, input payload_capacity,
                 input batch_end, output ready);
endinterface

interface rins_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] sorted_volume;
   logic [15:0] sorted_capacity;
   logic        final_record;
   logic        overflowed;

   modport source (output valid, output sorted_volume, output sorted_capacity,
                   output final_record, output overflowed, input ready);
   modport sink (input valid, input sorted_volume, input sorted_capacity,
                 input final_record, input overflowed, output ready);
endinterface

>>> sv/rins_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rins_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/rins_ctrl.sv
// Sequencer of the record insertion sorter: load, insertion pass with one
// shared key comparator, and readout. Depends on rins_pkg; drives rins_ram.
module rins_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rins_pkg::entry_type   req_entry,
   input  logic                  req_last,
   input  logic                  rsp_ready,
   input  rins_pkg::entry_type   rd_data,
   output rins_pkg::ram_req_type ram,
   output rins_pkg::emit_type    emit
);
   import rins_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_BITS-1:0] a_ff, a_in;
   logic [IDX_BITS-1:0] b_ff, b_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   entry_type           hold_ff, hold_in;
   logic                key_gt;
   logic                is_last;

   assign key_gt  = rd_data.key > hold_ff.key;
   assign is_last = CNT_BITS'(idx_ff) == (count_ff - CNT_BITS'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = (a_ff == count_ff) ? ST_READ : ST_KEY;
         end
         ST_KEY: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (key_gt) begin
               state_in = (b_ff == IDX_BITS'(1)) ? ST_PLACE : ST_SHIFT;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_PLACE: state_in = ST_FETCH;
         ST_READ:  state_in = ST_LATCH;
         ST_LATCH: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_ready) state_in = is_last ? ST_LOAD : ST_READ;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      ram.wr_en      = 1'b0;
      ram.wr_addr    = count_ff[IDX_BITS-1:0];
      ram.wr_data    = req_entry;
      ram.rd_addr    = a_ff[IDX_BITS-1:0];
      emit.latch     = 1'b0;
      emit.valid     = 1'b0;
      emit.final_rec = is_last;
      emit.overflow  = ovf_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      idx_in         = idx_ff;
      hold_in        = hold_ff;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < CNT_BITS'(MAX_RECORDS)) begin
                  ram.wr_en = 1'b1;
                  count_in  = count_ff + CNT_BITS'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  a_in   = CNT_BITS'(1);
                  idx_in = '0;
               end
            end
         end
         ST_FETCH: begin
            ram.rd_addr = a_ff[IDX_BITS-1:0];
         end
         ST_KEY: begin
            hold_in     = rd_data;
            b_in        = a_ff[IDX_BITS-1:0];
            ram.rd_addr = a_ff[IDX_BITS-1:0] - IDX_BITS'(1);
         end
         ST_SHIFT: begin
            ram.wr_en   = 1'b1;
            ram.wr_addr = b_ff;
            if (key_gt) begin
               ram.wr_data = rd_data;
               b_in        = b_ff - IDX_BITS'(1);
               ram.rd_addr = b_ff - IDX_BITS'(2);
            end else begin
               ram.wr_data = hold_ff;
               a_in        = a_ff + CNT_BITS'(1);
            end
         end
         ST_PLACE: begin
            ram.wr_en   = 1'b1;
            ram.wr_addr = '0;
            ram.wr_data = hold_ff;
            a_in        = a_ff + CNT_BITS'(1);
         end
         ST_READ: begin
            ram.rd_addr = idx_ff;
         end
         ST_LATCH: begin
            emit.latch = 1'b1;
         end
         ST_OUT: begin
            emit.valid = 1'b1;
            if (rsp_ready) begin
               if (is_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  idx_in = idx_ff + IDX_BITS'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      idx_ff  <= idx_in;
      hold_ff <= hold_in;
   end
endmodule

>>> sv/record_insertion_sorter.sv
// Record insertion sorter: collects a batch of key/payload records and
// emits them sorted ascending by key, stable for equal keys.
// Depends on rins_pkg, rins_if, rins_ram and rins_ctrl.
//
// Request channel (req_if): one record per item; batch_end marks the last.
// Records are written one per cycle into a MAX_RECORDS-deep store; while the
// store is full further records are dropped and overflowed is set on every
// response item of that batch.
// After the last record the sorter runs an in-place insertion pass over the
// store through a single comparator: each record is fetched and its key
// held, every larger record before it is shifted up by one place, and the
// record is then written into the slot left free.
// req_if.ready is low until the whole batch has been delivered.
// Response channel (rsp_if): one item per stored record, in sorted order,
// final_record high on the last. Each item passes through a store read, an
// output register load and presentation; it is held in the output register
// while the receiver stalls, and the next read starts only once it has been
// taken.
// Reset (synchronous, active high) empties the batch and returns to loading;
// store contents are not cleared.
module record_insertion_sorter (
   input logic        clock,
   input logic        reset,
   rins_req_if.sink   req_if,
   rins_rsp_if.source rsp_if
);
   import rins_pkg::*;

   entry_type   req_entry;
   entry_type   rd_data;
   ram_req_type ram;
   emit_type    emit;
   entry_type   out_ff;
   logic        final_ff;
   logic        ovf_out_ff;

   assign req_entry.key = KEY_BITS'(32'(req_if.key_volume));
   assign req_entry.pay = req_if.payload_capacity;

   rins_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .req_entry (req_entry),
      .req_last  (req_if.batch_end),
      .rsp_ready (rsp_if.ready),
      .rd_data   (rd_data),
      .ram       (ram),
      .emit      (emit)
   );

   rins_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_RECORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram.wr_en),
      .wr_addr (ram.wr_addr),
      .wr_data (ram.wr_data),
      .rd_addr (ram.rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (emit.latch) begin
         out_ff     <= rd_data;
         final_ff   <= emit.final_rec;
         ovf_out_ff <= emit.overflow;
      end
   end

   assign rsp_if.valid           = emit.valid;
   assign rsp_if.sorted_volume   = 16'(32'(out_ff.key));
   assign rsp_if.sorted_capacity = out_ff.pay;
   assign rsp_if.final_record    = final_ff;
   assign rsp_if.overflowed      = ovf_out_ff;
endmodule
